// File: rtl/core/lcgd_pkg.sv
// ----------------------------------------------------------------------------
// lcgd_pkg
// Shared types and constants for the linear projection CTC greedy decoder.
// ----------------------------------------------------------------------------
package lcgd_pkg;

   // Default sizes, handed to the top-level parameters
   localparam int IN_FEATURES_DEF = 192;
   localparam int NUM_CLASSES_DEF = 11;
   localparam int MAX_STEPS_DEF   = 256;

   // Blank symbol of the CTC alphabet
   localparam int BLANK_CLASS = 10;

   // Fixed field widths
   localparam int KIND_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int BIAS_W     = 32;
   localparam int ADDR_W     = 12;
   localparam int VSTEPS_W   = 9;
   localparam int DIGIT_W    = 4;
   localparam int PROD_W     = 32;   // Q6.25 product of Q4.11 and Q1.14
   localparam int SUM_W      = 40;   // saturating class sums

   // Item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_FEATURE = 2'd0,
      KIND_WEIGHT  = 2'd1,
      KIND_BIAS    = 2'd2
   } kind_type;

   // Input beat
   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [BIAS_W-1:0]   bias_word;
      logic [ADDR_W-1:0]          table_address;
      logic [VSTEPS_W-1:0]        valid_steps;
      logic                       sequence_end;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               digit_valid;
      logic               end_of_text;
   } rsp_type;

   // Per-element control that rides along the MAC pipeline
   typedef struct packed {
      logic feat;      // feature element present
      logic bias_wr;   // bias write present
      logic first;     // first element of a step
      logic last;      // last element of a step
      logic decode;    // step is below the step limit
      logic seq_end;   // final element of the sequence
   } mac_ctrl_type;

   // Decision token that travels with the class sums through the argmax tree
   typedef struct packed {
      logic valid;
      logic decode;
      logic seq_end;
   } tok_type;

endpackage

// File: rtl/core/lcgd_weight_lanes.sv
// ----------------------------------------------------------------------------
// lcgd_weight_lanes
// One weight memory per class lane, written one word at a time and read
// across all lanes at the current feature position, with registered data.
// ----------------------------------------------------------------------------
module lcgd_weight_lanes #(
   parameter int IN_FEATURES = lcgd_pkg::IN_FEATURES_DEF,
   parameter int NUM_CLASSES = lcgd_pkg::NUM_CLASSES_DEF,
   parameter int POS_W       = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [lcgd_pkg::ADDR_W-1:0]          wr_addr,
   input  logic signed [lcgd_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [POS_W-1:0]                     rd_row,
   output logic signed [lcgd_pkg::SAMPLE_W-1:0] rd_data [NUM_CLASSES]
);
   import lcgd_pkg::*;

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
      localparam int BASE = c * IN_FEATURES;

      logic signed [SAMPLE_W-1:0] mem [IN_FEATURES];
      logic                       hit;
      logic [POS_W-1:0]           row;

      // class*IN_FEATURES+feature: lane owns one contiguous address range
      assign hit = (32'(wr_addr) >= 32'(BASE)) && (32'(wr_addr) < 32'(BASE + IN_FEATURES));
      assign row = POS_W'(32'(wr_addr) - 32'(BASE));

      always_ff @(posedge clock) begin
         if (wr_en && hit) begin
            mem[row] <= wr_data;
         end
         if (rd_en) begin
            rd_data[c] <= mem[rd_row];
         end
      end
   end

endmodule

// File: rtl/core/lcgd_mac_lanes.sv
// ----------------------------------------------------------------------------
// lcgd_mac_lanes
// Per-class multiply, then saturating accumulate into the class sums. Bias
// writes are applied at the accumulate stage so they stay in item order.
// ----------------------------------------------------------------------------
module lcgd_mac_lanes #(
   parameter int NUM_CLASSES = lcgd_pkg::NUM_CLASSES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcgd_pkg::mac_ctrl_type               ctrl,
   input  logic signed [lcgd_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [lcgd_pkg::SAMPLE_W-1:0] weights [NUM_CLASSES],
   input  logic signed [lcgd_pkg::BIAS_W-1:0]   bias_word,
   input  logic [lcgd_pkg::ADDR_W-1:0]          bias_addr,
   output logic signed [lcgd_pkg::SUM_W-1:0]    sums [NUM_CLASSES],
   output lcgd_pkg::tok_type                    tok
);
   import lcgd_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   mac_ctrl_type             ctrl2_ff;
   logic signed [BIAS_W-1:0] bias2_ff;
   logic [ADDR_W-1:0]        baddr2_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_CLASSES];
   logic signed [BIAS_W-1:0] bias_ff [NUM_CLASSES];
   logic signed [SUM_W-1:0]  sums_ff [NUM_CLASSES];
   logic signed [SUM_W-1:0]  sums_in [NUM_CLASSES];
   tok_type                  tok_ff;
   tok_type                  tok_in;

   // Control for the accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
         tok_ff   <= '0;
      end else begin
         ctrl2_ff <= ctrl;
         tok_ff   <= tok_in;
      end
   end

   // A step boundary or a sequence end hands the sums to the argmax tree
   always_comb begin
      tok_in.valid   = ctrl2_ff.feat && (ctrl2_ff.last || ctrl2_ff.seq_end);
      tok_in.decode  = ctrl2_ff.last && ctrl2_ff.decode;
      tok_in.seq_end = ctrl2_ff.seq_end;
   end

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_mac
      logic signed [SUM_W-1:0] base;
      logic signed [SUM_W:0]   wide;

      // Step opens from the bias, otherwise from the running sum
      assign base = ctrl2_ff.first ?
                    {{(SUM_W-BIAS_W){bias_ff[c][BIAS_W-1]}}, bias_ff[c]} : sums_ff[c];
      assign wide = {base[SUM_W-1], base} +
                    {{(SUM_W+1-PROD_W){prod_ff[c][PROD_W-1]}}, prod_ff[c]};

      // Saturate on overflow of the 40-bit range
      always_comb begin
         if (wide[SUM_W] != wide[SUM_W-1]) begin
            sums_in[c] = wide[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            sums_in[c] = wide[SUM_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         prod_ff[c] <= sample * weights[c];
         if (ctrl2_ff.bias_wr && (baddr2_ff == ADDR_W'(c))) begin
            bias_ff[c] <= bias2_ff;
         end
         if (ctrl2_ff.feat) begin
            sums_ff[c] <= sums_in[c];
         end
      end

      assign sums[c] = sums_ff[c];
   end

   // Bias write data follows the multiply stage
   always_ff @(posedge clock) begin
      bias2_ff  <= bias_word;
      baddr2_ff <= bias_addr;
   end

   assign tok = tok_ff;

endmodule

// File: rtl/core/lcgd_argmax_tree.sv
// ----------------------------------------------------------------------------
// lcgd_argmax_tree
// Registered pairwise max tree over the class sums, one register per level.
// On equal sums the lower class index wins.
// ----------------------------------------------------------------------------
module lcgd_argmax_tree #(
   parameter int NUM_CLASSES = lcgd_pkg::NUM_CLASSES_DEF,
   parameter int CLS_W       = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [lcgd_pkg::SUM_W-1:0] sums [NUM_CLASSES],
   input  lcgd_pkg::tok_type                 tok,
   output logic [CLS_W-1:0]                  best,
   output lcgd_pkg::tok_type                 best_tok
);
   import lcgd_pkg::*;

   localparam int TREE_LEVELS = CLS_W;

   logic signed [SUM_W-1:0] val_ff  [TREE_LEVELS][NUM_CLASSES];
   logic [CLS_W-1:0]        idx_ff  [TREE_LEVELS][NUM_CLASSES];
   logic signed [SUM_W-1:0] src_val [TREE_LEVELS][NUM_CLASSES];
   logic [CLS_W-1:0]        src_idx [TREE_LEVELS][NUM_CLASSES];
   tok_type                 tok_ff  [TREE_LEVELS];

   // Live entries at the input of a level
   function automatic int level_count(input int l);
      return (NUM_CLASSES + (1 << l) - 1) >> l;
   endfunction

   // Inputs of each level: the sums, then the previous level
   always_comb begin
      for (int l = 0; l < TREE_LEVELS; l++) begin
         for (int j = 0; j < NUM_CLASSES; j++) begin
            if (l == 0) begin
               src_val[l][j] = sums[j];
               src_idx[l][j] = CLS_W'(j);
            end else begin
               src_val[l][j] = val_ff[l-1][j];
               src_idx[l][j] = idx_ff[l-1][j];
            end
         end
      end
   end

   // Pairwise compare; the upper entry wins only when strictly larger
   always_ff @(posedge clock) begin
      for (int l = 0; l < TREE_LEVELS; l++) begin
         for (int j = 0; j < NUM_CLASSES; j++) begin
            if (2*j + 1 < level_count(l)) begin
               if (src_val[l][2*j+1] > src_val[l][2*j]) begin
                  val_ff[l][j] <= src_val[l][2*j+1];
                  idx_ff[l][j] <= src_idx[l][2*j+1];
               end else begin
                  val_ff[l][j] <= src_val[l][2*j];
                  idx_ff[l][j] <= src_idx[l][2*j];
               end
            end else if (2*j < level_count(l)) begin
               val_ff[l][j] <= src_val[l][2*j];
               idx_ff[l][j] <= src_idx[l][2*j];
            end else begin
               val_ff[l][j] <= '0;
               idx_ff[l][j] <= '0;
            end
         end
      end
   end

   // Token follows the tree levels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < TREE_LEVELS; l++) begin
            tok_ff[l] <= '0;
         end
      end else begin
         tok_ff[0] <= tok;
         for (int l = 1; l < TREE_LEVELS; l++) begin
            tok_ff[l] <= tok_ff[l-1];
         end
      end
   end

   assign best     = idx_ff[TREE_LEVELS-1][0];
   assign best_tok = tok_ff[TREE_LEVELS-1];

endmodule

// File: rtl/core/lcgd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// lcgd_rsp_fifo
// Small result queue in front of the rsp channel. Space is reserved
// upstream, so a push always finds a free entry.
// ----------------------------------------------------------------------------
module lcgd_rsp_fifo #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcgd_pkg::rsp_type push_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcgd_pkg::rsp_type rsp_data
);
   import lcgd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem[rd_ptr_ff];
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(DEPTH)))
      else $error("result pushed into a full queue");

endmodule

// File: rtl/core/linear_argmax_ctc_greedy_decode_unit.sv
// ----------------------------------------------------------------------------
// linear_argmax_ctc_greedy_decode_unit
// Path: the element closing a step passes the input register, the multiply and
//   accumulate registers, the argmax tree levels and the result queue.
// Throughput: one beat per cycle of any kind; the weight lanes, MAC lanes
//   and argmax tree are fully pipelined, gated only by result queue credits.
// Reset: step state cleared, previous class set to blank; weight and bias
//   stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module linear_argmax_ctc_greedy_decode_unit #(
   parameter int IN_FEATURES = lcgd_pkg::IN_FEATURES_DEF,
   parameter int NUM_CLASSES = lcgd_pkg::NUM_CLASSES_DEF,
   parameter int MAX_STEPS   = lcgd_pkg::MAX_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcgd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcgd_pkg::rsp_type rsp_data
);
   import lcgd_pkg::*;

   localparam int POS_W       = (IN_FEATURES > 1) ? $clog2(IN_FEATURES) : 1;
   localparam int STEP_W      = $clog2(MAX_STEPS + 1);
   localparam int CLS_W       = $clog2(NUM_CLASSES);
   localparam int PREV_W      = (CLS_W > DIGIT_W) ? CLS_W : DIGIT_W;
   localparam int TREE_LEVELS = CLS_W;
   localparam int FIFO_DEPTH  = 2 ** $clog2(TREE_LEVELS + 5);
   localparam int CRED_W      = $clog2(FIFO_DEPTH + 1);

   // Input side
   logic                accept;
   logic                is_feat;
   logic                at_first;
   logic                at_last;
   logic [STEP_W-1:0]   vsteps_clip;
   logic [STEP_W-1:0]   limit_now;
   logic                take;

   // Sequence position
   logic [POS_W-1:0]    feat_pos_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   limit_ff;

   // First pipeline stage
   mac_ctrl_type               s1_ctrl_ff;
   mac_ctrl_type               s1_ctrl_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic signed [BIAS_W-1:0]   s1_bias_ff;
   logic [ADDR_W-1:0]          s1_baddr_ff;
   logic signed [SAMPLE_W-1:0] weights [NUM_CLASSES];

   // Sums and decision
   logic signed [SUM_W-1:0] sums [NUM_CLASSES];
   tok_type                 sum_tok;
   logic [CLS_W-1:0]        best;
   tok_type                 best_tok;
   logic [PREV_W-1:0]       prev_class_ff;
   logic                    emit;
   logic                    push;
   logic                    drop;
   rsp_type                 push_data;
   logic                    pop;

   // Result queue credits
   logic [CRED_W-1:0] credit_ff;
   logic [CRED_W-1:0] credit_in;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (credit_ff == '0);
   assign is_feat   = (req_data.kind == KIND_FEATURE);
   assign at_first  = (feat_pos_ff == '0);
   assign at_last   = (feat_pos_ff == POS_W'(IN_FEATURES - 1));

   // Step limit is latched on the first element of a sequence
   assign vsteps_clip = (32'(req_data.valid_steps) < 32'(MAX_STEPS)) ?
                        STEP_W'(req_data.valid_steps) : STEP_W'(MAX_STEPS);
   assign limit_now   = (at_first && (step_ff == '0)) ? vsteps_clip : limit_ff;

   // Control handed to the MAC lanes
   always_comb begin
      s1_ctrl_in.feat    = accept && is_feat;
      s1_ctrl_in.bias_wr = accept && (req_data.kind == KIND_BIAS);
      s1_ctrl_in.first   = at_first;
      s1_ctrl_in.last    = at_last;
      s1_ctrl_in.decode  = (step_ff < limit_now);
      s1_ctrl_in.seq_end = req_data.sequence_end;
   end

   // Feature position, step count and step limit
   always_ff @(posedge clock) begin
      if (reset) begin
         feat_pos_ff <= '0;
         step_ff     <= '0;
         limit_ff    <= '0;
         s1_ctrl_ff  <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
         if (accept && is_feat) begin
            if (req_data.sequence_end) begin
               feat_pos_ff <= '0;
               step_ff     <= '0;
               limit_ff    <= '0;
            end else begin
               limit_ff <= limit_now;
               if (at_last) begin
                  feat_pos_ff <= '0;
                  if (step_ff != STEP_W'(MAX_STEPS)) begin
                     step_ff <= step_ff + 1'b1;
                  end
               end else begin
                  feat_pos_ff <= feat_pos_ff + 1'b1;
               end
            end
         end
      end
   end

   // Payload aligned with the weight read
   always_ff @(posedge clock) begin
      s1_sample_ff <= req_data.sample;
      s1_bias_ff   <= req_data.bias_word;
      s1_baddr_ff  <= req_data.table_address;
   end

   lcgd_weight_lanes #(
      .IN_FEATURES (IN_FEATURES),
      .NUM_CLASSES (NUM_CLASSES),
      .POS_W       (POS_W)
   ) u_weights (
      .clock   (clock),
      .wr_en   (accept && (req_data.kind == KIND_WEIGHT)),
      .wr_addr (req_data.table_address),
      .wr_data (req_data.sample),
      .rd_en   (accept && is_feat),
      .rd_row  (feat_pos_ff),
      .rd_data (weights)
   );

   lcgd_mac_lanes #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (s1_ctrl_ff),
      .sample    (s1_sample_ff),
      .weights   (weights),
      .bias_word (s1_bias_ff),
      .bias_addr (s1_baddr_ff),
      .sums      (sums),
      .tok       (sum_tok)
   );

   lcgd_argmax_tree #(
      .NUM_CLASSES (NUM_CLASSES),
      .CLS_W       (CLS_W)
   ) u_argmax (
      .clock    (clock),
      .reset    (reset),
      .sums     (sums),
      .tok      (sum_tok),
      .best     (best),
      .best_tok (best_tok)
   );

   // Greedy collapse: drop blanks and repeats of the previous step's class
   assign emit = best_tok.valid && best_tok.decode &&
                 (32'(best) != BLANK_CLASS) && (PREV_W'(best) != prev_class_ff);
   assign push = best_tok.valid && (emit || best_tok.seq_end);
   assign drop = best_tok.valid && !push;

   always_comb begin
      push_data.digit       = emit ? DIGIT_W'(best) : '0;
      push_data.digit_valid = emit;
      push_data.end_of_text = best_tok.seq_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_class_ff <= PREV_W'(BLANK_CLASS);
      end else if (best_tok.valid) begin
         if (best_tok.seq_end) begin
            prev_class_ff <= PREV_W'(BLANK_CLASS);
         end else if (best_tok.decode) begin
            prev_class_ff <= PREV_W'(best);
         end
      end
   end

   // One credit per element that may produce a beat, returned on pop or drop
   assign take      = accept && is_feat && (at_last || req_data.sequence_end);
   assign credit_in = credit_ff - CRED_W'(take) + CRED_W'(pop) + CRED_W'(drop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= CRED_W'(FIFO_DEPTH);
      end else begin
         credit_ff <= credit_in;
      end
   end

   lcgd_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRED_W'(FIFO_DEPTH))
      else $error("result credits exceed queue depth");

   a_pos_bound : assert property (@(posedge clock) disable iff (reset)
      feat_pos_ff <= POS_W'(IN_FEATURES - 1))
      else $error("feature position past end of step");

   a_prev_tracks : assert property (@(posedge clock) disable iff (reset)
      (emit && !best_tok.seq_end) |=> (prev_class_ff == $past(PREV_W'(best))))
      else $error("previous class not updated after emitted digit");

   a_no_credit_no_take : assert property (@(posedge clock) disable iff (reset)
      take |-> (credit_ff != '0))
      else $error("element accepted without a free result credit");

endmodule

// File: verif/tb_linear_argmax_ctc_greedy_decode_unit.sv
// ----------------------------------------------------------------------------
// tb_linear_argmax_ctc_greedy_decode_unit
// Self-checking bench for the linear projection CTC greedy decoder. Weights
// and biases are loaded first, then a scripted pass walks ties, the blank
// class, step limits, partial steps, ignored beats and step count saturation.
// A receiver hold-off backs up the result path, then the tables are reloaded
// with random content and random sequences run under three pacing schemes.
// Every result beat is compared against an in-bench projection and argmax.
// ----------------------------------------------------------------------------
module tb_linear_argmax_ctc_greedy_decode_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lcgd_pkg::*;

   localparam int FEATS        = IN_FEATURES_DEF;
   localparam int CLASSES      = NUM_CLASSES_DEF;
   localparam int STEP_CAP     = MAX_STEPS_DEF;
   localparam int WEIGHT_DEPTH = FEATS * CLASSES;
   localparam longint ACC_MAX  = 64'sd549755813887;
   localparam longint ACC_MIN  = -ACC_MAX - 64'sd1;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 1350;
   localparam int RANDOM_RESULTS = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int BURST_BEATS   = 64;
   localparam int DRAIN_CYCLES  = 40;
   localparam int SCRIPT_ROWS   = 23;

   // Pacing schemes: which side idles, and how often (percent of cycles)
   typedef enum int {RX_SLOW = 0, TX_SLOW = 1, FULL_RATE = 2} pace_t;
   int tx_idle_pct [3] = '{19, 74, 0};
   int rx_idle_pct [3] = '{74, 19, 0};

   // One scripted row: a beat repeated reps times; sequence_end only on the
   // last repetition. Typed rows carry their own answer for that last beat.
   typedef struct packed {
      req_type beat;
      int      reps;
      logic    typed;
      logic    has_sym;
      rsp_type sym;
   } plan_row_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pace_t pace = FULL_RATE;
   logic  hold_request = 1'b0;
   bit    hold_taken = 1'b0;
   int    hold_left = 0;

   rsp_type symbol_queue [$];
   int      symbols_sent = 0;
   int      mismatches = 0;
   int      live_items = 0;

   // Decoder image: tables, class sums and step state
   logic signed [SAMPLE_W-1:0] weight_mem [WEIGHT_DEPTH];
   logic signed [BIAS_W-1:0]   bias_mem [CLASSES];
   longint class_acc [CLASSES];
   int feat_pos = 0;
   int step_cnt = 0;
   int step_lim = 0;
   int prev_cls = BLANK_CLASS;

   // Scripted pass; starts from all-zero weights and all-zero biases
   plan_row_t script [SCRIPT_ROWS] = '{
      // all sums zero: tie, lowest class wins and is new
      '{'{KIND_FEATURE, 16'sh0000, 32'sh0, 12'd0, 9'd3, 1'b0}, 192, 1'b1, 1'b1,
        '{4'd0, 1'b1, 1'b0}},
      // same class again: nothing emitted
      '{'{KIND_FEATURE, 16'sh7fff, 32'sh0, 12'd0, 9'd3, 1'b0}, 192, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh7fff_ffff, 12'd10, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      // blank wins: nothing emitted
      '{'{KIND_FEATURE, 16'sh8000, 32'sh0, 12'd0, 9'd3, 1'b0}, 192, 1'b1, 1'b0, '0},
      // step past the limit, sequence closes: end of text only
      '{'{KIND_FEATURE, 16'sh0000, 32'sh0, 12'd0, 9'd3, 1'b1}, 192, 1'b1, 1'b1,
        '{4'd0, 1'b0, 1'b1}},
      '{'{KIND_BIAS, 16'sh0, 32'sh7fff_ffff, 12'd7, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      // sequence closes mid-step: partial step dropped
      '{'{KIND_FEATURE, 16'sh0005, 32'sh0, 12'd0, 9'd0, 1'b1}, 5, 1'b1, 1'b1,
        '{4'd0, 1'b0, 1'b1}},
      // class 7 ties blank and wins; digit and end of text in one beat
      '{'{KIND_FEATURE, 16'shffff, 32'sh0, 12'd0, 9'd511, 1'b1}, 192, 1'b1, 1'b1,
        '{4'd7, 1'b1, 1'b1}},
      // unused kind, out-of-range weight and bias writes: all ignored
      '{'{KIND_UNUSED, 16'sh8000, 32'sh8000_0000, 12'hfff, 9'h1ff, 1'b1}, 1, 1'b1,
        1'b0, '0},
      '{'{KIND_WEIGHT, 16'sh7fff, 32'sh0, 12'hfff, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_WEIGHT, 16'sh8000, 32'sh0, 12'd2112, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh8000_0000, 12'd11, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh8000_0000, 12'hfff, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      // tables untouched by the ignored writes: class 7 again
      '{'{KIND_FEATURE, 16'sh1234, 32'sh0, 12'd0, 9'd511, 1'b1}, 192, 1'b1, 1'b1,
        '{4'd7, 1'b1, 1'b1}},
      // extreme weights at both ends of the table, extreme biases
      '{'{KIND_WEIGHT, 16'sh8000, 32'sh0, 12'd2111, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_WEIGHT, 16'sh7fff, 32'sh0, 12'd0, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh8000_0000, 12'd10, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh8000_0000, 12'd7, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_BIAS, 16'sh0, 32'sh7fff_ffff, 12'd0, 9'd0, 1'b0}, 1, 1'b1, 1'b0, '0},
      '{'{KIND_FEATURE, 16'sh8000, 32'sh0, 12'd0, 9'd256, 1'b0}, 1, 1'b0, 1'b0, '0},
      '{'{KIND_FEATURE, 16'sh8000, 32'sh0, 12'd0, 9'd0, 1'b0}, 190, 1'b0, 1'b0, '0},
      '{'{KIND_FEATURE, 16'sh8000, 32'sh0, 12'd0, 9'd0, 1'b1}, 1, 1'b0, 1'b0, '0},
      // one step more than the counter holds
      '{'{KIND_FEATURE, 16'sh0100, 32'sh0, 12'd0, 9'd256, 1'b1}, 192 * 257, 1'b0,
        1'b0, '0}
   };

   linear_argmax_ctc_greedy_decode_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Saturating add into a 40-bit class sum
   function automatic longint sum_saturate(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > ACC_MAX) return ACC_MAX;
      if (s < ACC_MIN) return ACC_MIN;
      return s;
   endfunction

   // Project one beat into the class sums and run the greedy decision
   function automatic bit project_and_decode(input req_type beat, output rsp_type sym);
      longint feat;
      longint wt;
      int     best;
      bit     emit;
      bit     done;
      emit = 1'b0;
      done = 1'b0;
      sym  = '0;
      if (beat.kind == KIND_WEIGHT) begin
         if (beat.table_address < WEIGHT_DEPTH) weight_mem[beat.table_address] = beat.sample;
         return 1'b0;
      end
      if (beat.kind == KIND_BIAS) begin
         if (beat.table_address < CLASSES) bias_mem[beat.table_address] = beat.bias_word;
         return 1'b0;
      end
      if (beat.kind != KIND_FEATURE) return 1'b0;

      // first element of a step: sums start from the biases
      if (feat_pos == 0) begin
         if (step_cnt == 0)
            step_lim = (beat.valid_steps < STEP_CAP) ? int'(beat.valid_steps) : STEP_CAP;
         for (int c = 0; c < CLASSES; c++) class_acc[c] = $signed(bias_mem[c]);
      end
      feat = $signed(beat.sample);
      for (int c = 0; c < CLASSES; c++) begin
         wt = $signed(weight_mem[c * FEATS + feat_pos]);
         class_acc[c] = sum_saturate(class_acc[c], feat * wt);
      end

      // last element of a step: argmax, lower index wins ties
      if (feat_pos + 1 >= FEATS) begin
         feat_pos = 0;
         if (step_cnt < step_lim) begin
            best = 0;
            for (int c = 1; c < CLASSES; c++)
               if (class_acc[c] > class_acc[best]) best = c;
            if (best != BLANK_CLASS && best != prev_cls) begin
               emit = 1'b1;
               sym.digit = best[DIGIT_W-1:0];
            end
            prev_cls = best;
         end
         if (step_cnt < STEP_CAP) step_cnt++;
      end else begin
         feat_pos++;
      end

      if (beat.sequence_end) begin
         done     = 1'b1;
         feat_pos = 0;
         step_cnt = 0;
         step_lim = 0;
         prev_cls = BLANK_CLASS;
      end
      sym.digit_valid = emit;
      sym.end_of_text = done;
      return emit || done;
   endfunction

   function automatic req_type random_beat();
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      req_type     b;
      r0 = $urandom;
      r1 = $urandom;
      r2 = $urandom;
      b.kind          = r0[1:0];
      b.sample        = r0[31:16];
      b.bias_word     = r1;
      b.table_address = r2[11:0];
      b.valid_steps   = r2[20:12];
      b.sequence_end  = r2[21];
      return b;
   endfunction

   // Feature or weight value, full scale with a share of corner values
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [31:0] r;
      r = $urandom;
      if (r[3:0] == 4'd0) begin
         case (r[5:4])
            2'd0:    return 16'h8000;
            2'd1:    return 16'h7fff;
            2'd2:    return 16'h0000;
            default: return 16'hffff;
         endcase
      end
      return r[31:16];
   endfunction

   // Table writes (mostly in range) and unused-kind beats between elements
   function automatic req_type noise_beat();
      req_type b;
      b = random_beat();
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            b.kind = KIND_WEIGHT;
            if ($urandom_range(4) != 0)
               b.table_address = ADDR_W'($urandom_range(0, WEIGHT_DEPTH - 1));
         end
         4, 5, 6: begin
            b.kind = KIND_BIAS;
            if ($urandom_range(4) != 0)
               b.table_address = ADDR_W'($urandom_range(0, CLASSES - 1));
         end
         default: b.kind = KIND_UNUSED;
      endcase
      return b;
   endfunction

   // Present one beat until accepted, then predict its result
   task automatic drive_beat(input req_type beat, output bit has, output rsp_type sym);
      while ($urandom_range(99) < tx_idle_pct[pace]) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      has = project_and_decode(beat, sym);
   endtask

   task automatic send_beat(input req_type beat);
      bit      has;
      rsp_type sym;
      drive_beat(beat, has, sym);
      if (has) begin
         symbol_queue.push_back(sym);
         symbols_sent++;
      end
   endtask

   // Random-phase send; beats the block ignores are not counted
   task automatic offer_random(input req_type beat);
      if (beat.kind == KIND_FEATURE ||
          (beat.kind == KIND_WEIGHT && beat.table_address < WEIGHT_DEPTH) ||
          (beat.kind == KIND_BIAS && beat.table_address < CLASSES))
         live_items++;
      send_beat(beat);
   endtask

   // Result side stall, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct[pace]);
      end
   end

   // Result checker
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (symbol_queue.size() == 0) begin
            $error("unexpected result beat: digit %0d digit_valid %0b end_of_text %0b",
                   rsp_data.digit, rsp_data.digit_valid, rsp_data.end_of_text);
            mismatches++;
         end else begin
            want = symbol_queue.pop_front();
            if (rsp_data.digit !== want.digit) begin
               $error("digit: expected %0d, actual %0d", want.digit, rsp_data.digit);
               mismatches++;
            end
            if (rsp_data.digit_valid !== want.digit_valid) begin
               $error("digit_valid: expected %0b, actual %0b",
                      want.digit_valid, rsp_data.digit_valid);
               mismatches++;
            end
            if (rsp_data.end_of_text !== want.end_of_text) begin
               $error("end_of_text: expected %0b, actual %0b",
                      want.end_of_text, rsp_data.end_of_text);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      req_type   beat;
      plan_row_t row;
      bit        has;
      rsp_type   sym;
      bit        last_rep;
      int        len;
      int        pick;
      int        base;
      logic [VSTEPS_W-1:0] vs;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero weights and biases so the scripted answers read off directly
      pace <= FULL_RATE;
      beat = '0;
      beat.kind = KIND_WEIGHT;
      for (int a = 0; a < WEIGHT_DEPTH; a++) begin
         beat.table_address = ADDR_W'(a);
         send_beat(beat);
      end
      beat.kind = KIND_BIAS;
      for (int a = 0; a < CLASSES; a++) begin
         beat.table_address = ADDR_W'(a);
         send_beat(beat);
      end

      // scripted pass
      pace <= RX_SLOW;
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = script[i];
         for (int k = 0; k < row.reps; k++) begin
            last_rep = (k == row.reps - 1);
            beat = row.beat;
            beat.sequence_end = row.beat.sequence_end && last_rep;
            drive_beat(beat, has, sym);
            if (row.typed && last_rep) begin
               has = row.has_sym;
               sym = row.sym;
            end
            if (has) begin
               symbol_queue.push_back(sym);
               symbols_sent++;
            end
         end
      end

      // burst of short sequences while the receiver holds off
      pace <= FULL_RATE;
      hold_request <= 1'b1;
      for (int n = 0; n < BURST_BEATS; n++) begin
         beat = random_beat();
         beat.kind = KIND_FEATURE;
         beat.sample = pick_sample();
         beat.sequence_end = (n == BURST_BEATS - 1) || ($urandom_range(2) != 0);
         send_beat(beat);
      end

      // random tables
      pace <= TX_SLOW;
      for (int a = 0; a < WEIGHT_DEPTH; a++) begin
         beat = random_beat();
         beat.kind = KIND_WEIGHT;
         beat.sample = pick_sample();
         beat.table_address = ADDR_W'(a);
         send_beat(beat);
      end
      for (int a = 0; a < CLASSES; a++) begin
         beat = random_beat();
         beat.kind = KIND_BIAS;
         beat.table_address = ADDR_W'(a);
         send_beat(beat);
      end

      // random sequences: mostly short, some whole steps, a few long broken ones
      base = symbols_sent;
      while (live_items < RANDOM_ITEMS || symbols_sent - base < RANDOM_RESULTS) begin
         if (live_items < RANDOM_ITEMS / 3)
            pace <= RX_SLOW;
         else if (live_items < 2 * RANDOM_ITEMS / 3)
            pace <= TX_SLOW;
         else
            pace <= FULL_RATE;
         vs = ($urandom_range(3) == 0) ? VSTEPS_W'($urandom_range(0, 511))
                                       : VSTEPS_W'($urandom_range(0, 4));
         pick = $urandom_range(99);
         if (pick < 90)
            len = $urandom_range(1, 12);
         else if (pick < 98)
            len = $urandom_range(1, 2) * FEATS;
         else
            len = FEATS + $urandom_range(1, 40);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 4) offer_random(noise_beat());
            beat = random_beat();
            beat.kind = KIND_FEATURE;
            beat.sample = pick_sample();
            if (k == 0) beat.valid_steps = vs;
            beat.sequence_end = (k == len - 1);
            offer_random(beat);
         end
      end
      req_valid <= 1'b0;

      while (symbol_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
